// ----- sv/bpdc_pkg.sv -----
// Shared types and constants for the button press duration classifier.
package bpdc_pkg;

  // Fixed field widths
  localparam int unsigned MaskW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned IndexW   = 3;
  localparam int unsigned KindW    = 3;
  localparam int unsigned DelayW   = 7;
  localparam int unsigned CfgIdxW  = 1;

  // Default configuration
  localparam int unsigned DefButtonCount = 8;
  localparam int unsigned CmdDepth       = 2;
  localparam int unsigned ResDepth       = 4;

  localparam logic [LimitW-1:0] LongLimitReset = 16'd1000;
  localparam logic [LimitW-1:0] ContLimitReset = 16'd3000;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgLongLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgContLimit = 1'b1;

  // Requested check delays
  localparam logic [DelayW-1:0] DelaySleep = 7'd0;
  localparam logic [DelayW-1:0] DelayFast  = 7'd10;
  localparam logic [DelayW-1:0] DelaySlow  = 7'd100;

  typedef enum logic [KindW-1:0] {
    KindNone    = 3'd0,
    KindShort   = 3'd1,
    KindLong    = 3'd2,
    KindRelCont = 3'd3,
    KindCont    = 3'd4
  } kind_e;

  // One accepted evaluation
  typedef struct packed {
    logic [MaskW-1:0] clicked;
    logic [MaskW-1:0] level;
    logic [TimeW-1:0] now;
  } cmd_t;

  // One per-button result
  typedef struct packed {
    logic [IndexW-1:0] index;
    kind_e             kind;
    logic [DelayW-1:0] next_check;
    logic              last;
  } res_t;

  // Hold-time limits from the register file
  typedef struct packed {
    logic [LimitW-1:0] long_limit;
    logic [LimitW-1:0] cont_limit;
  } cfg_t;

endpackage

// ----- sv/bpdc_fifo.sv -----
// Small show-ahead queue used on the command and result sides.
module bpdc_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/bpdc_engine.sv -----
// Per-button sequencer: walks the buttons of one evaluation, one per cycle while the result queue is not full.
module bpdc_engine #(
  parameter int unsigned BUTTON_COUNT = bpdc_pkg::DefButtonCount
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpdc_pkg::cfg_t cfg_i,
  input  bpdc_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  output bpdc_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic          res_full_i
);

  import bpdc_pkg::*;

  localparam int unsigned IdxW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  logic [BUTTON_COUNT-1:0] held_q, held_d;
  logic [TimeW-1:0]        start_q [BUTTON_COUNT];
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [DelayW-1:0]       delay_q, delay_d;

  logic              go, last, click, held, level, held_new, request;
  logic [TimeW-1:0]  elapsed;
  logic              over_long, over_cont;
  logic [DelayW-1:0] req_delay, delay_now;
  kind_e             kind;

  assign go    = cmd_valid_i & ~res_full_i;
  assign last  = (idx_q == IdxW'(BUTTON_COUNT - 1));
  assign click = cmd_i.clicked[idx_q];
  assign level = cmd_i.level[idx_q];
  assign held  = held_q[idx_q];

  // Hold time, wrapping, against zero-extended limits
  assign elapsed   = cmd_i.now - start_q[idx_q];
  assign over_long = elapsed > {{(TimeW - LimitW){1'b0}}, cfg_i.long_limit};
  assign over_cont = elapsed > {{(TimeW - LimitW){1'b0}}, cfg_i.cont_limit};

  // Classify the current button
  always_comb begin
    kind      = KindNone;
    held_new  = held;
    request   = 1'b0;
    req_delay = DelaySleep;
    if (click) begin
      held_new  = 1'b1;
      request   = 1'b1;
      req_delay = DelayFast;
    end else if (held) begin
      if (!level) begin
        held_new = 1'b0;
        if (over_long) begin
          kind = over_cont ? KindRelCont : KindLong;
        end else begin
          kind = KindShort;
        end
      end else if (over_cont) begin
        kind      = KindCont;
        request   = 1'b1;
        req_delay = DelaySlow;
      end else begin
        request   = 1'b1;
        req_delay = DelayFast;
      end
    end
  end

  // The highest-numbered request wins
  assign delay_now = request ? req_delay : delay_q;

  assign res_o.index      = IndexW'(idx_q);
  assign res_o.kind       = kind;
  assign res_o.next_check = last ? delay_now : DelaySleep;
  assign res_o.last       = last;
  assign res_push_o       = go;
  assign cmd_pop_o        = go & last;

  // Step to the next button, restart after the last one
  always_comb begin
    held_d  = held_q;
    idx_d   = idx_q;
    delay_d = delay_q;
    if (go) begin
      held_d[idx_q] = held_new;
      idx_d         = last ? '0 : idx_q + 1'b1;
      delay_d       = last ? DelaySleep : delay_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      idx_q   <= '0;
      delay_q <= DelaySleep;
    end else begin
      held_q  <= held_d;
      idx_q   <= idx_d;
      delay_q <= delay_d;
    end
  end

  // Record the start tick of a fresh press
  always_ff @(posedge clk_i) begin
    if (go && click && !held) begin
      start_q[idx_q] <= cmd_i.now;
    end
  end

  // An evaluation is retired only with its final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (res_push_o && res_o.last))
    else $error("command retired without its final result");

  // A clicked button is tracked as held afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && click) |=> held_q[$past(idx_q)])
    else $error("click did not set the held flag");

  // Sequencer holds its position while the result queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && res_full_i) |=> (idx_q == $past(idx_q)))
    else $error("sequencer advanced while stalled");

  // Only a result carrying a release event changes the held state low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && held && !held_new) |-> (kind == KindShort || kind == KindLong ||
                                   kind == KindRelCont))
    else $error("held flag cleared without a release event");

endmodule

// ----- sv/button_press_duration_classifier.sv -----
// Top level of the button press duration classifier.
//
// Input channel: clicked_mask_i, level_mask_i and now_ms_i form one
// evaluation; it is taken on a rising edge with push high and full low.
// Result channel: while empty is low the oldest per-button result sits on
// button_index_o, event_kind_o, next_check_ms_o and last_result_o; pop high
// takes it. Each evaluation yields BUTTON_COUNT results in button order, the
// final one flagged by last_result_o and carrying the next check delay.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 long press limit, 1 continuous press limit) at the clock edge.
// An evaluation that is taken waits in the command queue; the sequencer
// writes its results into the result queue, one button per cycle while the
// result queue is not full. A small command queue keeps push open while the
// sequencer is busy; when the receiver stops popping, the result queue fills,
// the sequencer holds its place and full rises once the command queue is full.
// Reset clears all held flags, empties both queues and loads the default
// limits (1000 ms long, 3000 ms continuous).
module button_press_duration_classifier #(
  parameter int unsigned BUTTON_COUNT = bpdc_pkg::DefButtonCount
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpdc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bpdc_pkg::LimitW-1:0]      cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [bpdc_pkg::MaskW-1:0]       clicked_mask_i,
  input  logic [bpdc_pkg::MaskW-1:0]       level_mask_i,
  input  logic [bpdc_pkg::TimeW-1:0]       now_ms_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [bpdc_pkg::IndexW-1:0]      button_index_o,
  output logic [bpdc_pkg::KindW-1:0]       event_kind_o,
  output logic [bpdc_pkg::DelayW-1:0]      next_check_ms_o,
  output logic                             last_result_o
);

  import bpdc_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_empty, cmd_pop, res_push, res_full;

  // Register file writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLongLimit: cfg_d.long_limit = cfg_data_i;
        CfgContLimit: cfg_d.cont_limit = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_limit <= LongLimitReset;
      cfg_q.cont_limit <= ContLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cmd_in.clicked = clicked_mask_i;
  assign cmd_in.level   = level_mask_i;
  assign cmd_in.now     = now_ms_i;

  // Front: queue accepted evaluations
  bpdc_fifo #(
    .DEPTH (CmdDepth),
    .WIDTH ($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  // Back: walk the buttons of the oldest evaluation
  bpdc_engine #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_head),
    .cmd_valid_i (~cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Hold results until the receiver pops them
  bpdc_fifo #(
    .DEPTH (ResDepth),
    .WIDTH ($bits(res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign button_index_o  = res_head.index;
  assign event_kind_o    = res_head.kind;
  assign next_check_ms_o = res_head.next_check;
  assign last_result_o   = res_head.last;

endmodule

// ----- tb/button_press_duration_classifier_test.sv -----
// Testbench for the button press duration classifier: directed plan, then random press sequences.
`timescale 1ns / 1ps

module button_press_duration_classifier_test;
  import bpdc_pkg::*;

  localparam int NumButtons = DefButtonCount;
  localparam int QuietLimit = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [LimitW-1:0]   cfg_data_i;
  logic                push;
  logic                full;
  logic [MaskW-1:0]    clicked_mask_i;
  logic [MaskW-1:0]    level_mask_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                empty;
  logic                pop;
  logic [IndexW-1:0]   button_index_o;
  logic [KindW-1:0]    event_kind_o;
  logic [DelayW-1:0]   next_check_ms_o;
  logic                last_result_o;

  button_press_duration_classifier #(
    .BUTTON_COUNT(NumButtons)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .clicked_mask_i (clicked_mask_i),
    .level_mask_i   (level_mask_i),
    .now_ms_i       (now_ms_i),
    .empty          (empty),
    .pop            (pop),
    .button_index_o (button_index_o),
    .event_kind_o   (event_kind_o),
    .next_check_ms_o(next_check_ms_o),
    .last_result_o  (last_result_o)
  );

  // One row of the directed plan: either a limit update or an evaluation
  typedef struct {
    bit                is_cfg;
    bit                typed;
    logic [LimitW-1:0] long_lim;
    logic [LimitW-1:0] cont_lim;
    logic [MaskW-1:0]  clicked;
    logic [MaskW-1:0]  level;
    logic [TimeW-1:0]  tick;
    kind_e             kind;
    logic [DelayW-1:0] delay;
  } plan_row_t;

  plan_row_t         plan_q[$];
  res_t              exp_res_q[$];
  int                mismatch_cnt = 0;
  int                quiet_cycles = 0;
  bit                send_calm = 1'b0;

  // Predicted block state
  logic [MaskW-1:0]  held_q;
  logic [TimeW-1:0]  press_start_q [NumButtons];
  logic [LimitW-1:0] long_lim_q;
  logic [LimitW-1:0] cont_lim_q;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Classify one evaluation and advance the predicted held flags and start ticks
  function automatic void classify_eval(input logic [MaskW-1:0] clicked,
                                        input logic [MaskW-1:0] level,
                                        input logic [TimeW-1:0] tick,
                                        output res_t res [NumButtons]);
    logic [TimeW-1:0]  elapsed;
    logic [DelayW-1:0] delay;
    kind_e             kind;
    delay = DelaySleep;
    for (int b = 0; b < NumButtons; b++) begin
      kind = KindNone;
      elapsed = tick - press_start_q[b];
      if (clicked[b]) begin
        if (!held_q[b]) begin
          held_q[b] = 1'b1;
          press_start_q[b] = tick;
        end
        delay = DelayFast;
      end else if (held_q[b]) begin
        if (!level[b]) begin
          held_q[b] = 1'b0;
          if (elapsed > long_lim_q) kind = (elapsed > cont_lim_q) ? KindRelCont : KindLong;
          else kind = KindShort;
        end else if (elapsed > cont_lim_q) begin
          kind = KindCont;
          delay = DelaySlow;
        end else begin
          delay = DelayFast;
        end
      end
      res[b].index = b[IndexW-1:0];
      res[b].kind = kind;
      res[b].next_check = DelaySleep;
      res[b].last = 1'b0;
    end
    res[NumButtons-1].next_check = delay;
    res[NumButtons-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Plan builders
  task automatic plan_limits(input logic [LimitW-1:0] lng, input logic [LimitW-1:0] cnt);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.typed = 1'b0;
    row.long_lim = lng;
    row.cont_lim = cnt;
    plan_q.push_back(row);
  endtask

  task automatic plan_eval(input logic [MaskW-1:0] c, input logic [MaskW-1:0] l,
                           input logic [TimeW-1:0] t);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.typed = 1'b0;
    row.clicked = c;
    row.level = l;
    row.tick = t;
    row.kind = KindNone;
    row.delay = DelaySleep;
    plan_q.push_back(row);
  endtask

  task automatic plan_typed(input logic [MaskW-1:0] c, input logic [MaskW-1:0] l,
                            input logic [TimeW-1:0] t, input kind_e k,
                            input logic [DelayW-1:0] d);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.typed = 1'b1;
    row.clicked = c;
    row.level = l;
    row.tick = t;
    row.kind = k;
    row.delay = d;
    plan_q.push_back(row);
  endtask

  // Update both limits once every expected result has come back
  task automatic write_limits(input logic [LimitW-1:0] lng, input logic [LimitW-1:0] cnt);
    push <= 1'b0;
    while (exp_res_q.size() != 0) @(posedge clk_i);
    repeat (NumButtons + 2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgLongLimit;
    cfg_data_i <= lng;
    @(posedge clk_i);
    cfg_idx_i <= CfgContLimit;
    cfg_data_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    long_lim_q = lng;
    cont_lim_q = cnt;
  endtask

  // Offer one evaluation, hold it until taken, then queue its expected results
  task automatic send_eval(input logic [MaskW-1:0] clicked, input logic [MaskW-1:0] level,
                           input logic [TimeW-1:0] tick, input bit typed, input kind_e kind,
                           input logic [DelayW-1:0] delay);
    res_t pred [NumButtons];
    int   gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    clicked_mask_i <= clicked;
    level_mask_i <= level;
    now_ms_i <= tick;
    do @(posedge clk_i); while (full);
    classify_eval(clicked, level, tick, pred);
    for (int b = 0; b < NumButtons; b++) begin
      if (typed) begin
        pred[b].kind = kind;
        pred[b].next_check = (b == NumButtons - 1) ? delay : DelaySleep;
      end
      exp_res_q.push_back(pred[b]);
    end
  endtask

  // Stimulus: reset, directed plan, random press sequences
  initial begin : stimulus
    logic [MaskW-1:0]  phys;
    logic [MaskW-1:0]  flips;
    logic [MaskW-1:0]  c;
    logic [MaskW-1:0]  l;
    logic [TimeW-1:0]  tick;
    logic [LimitW-1:0] lng;
    logic [LimitW-1:0] cnt;
    int                span;
    int                pick;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgLongLimit;
    cfg_data_i <= '0;
    push <= 1'b0;
    clicked_mask_i <= '0;
    level_mask_i <= '0;
    now_ms_i <= '0;
    held_q = '0;
    long_lim_q = LongLimitReset;
    cont_lim_q = ContLimitReset;
    for (int b = 0; b < NumButtons; b++) press_start_q[b] = '0;

    // Default limits after reset: idle, press all, hold, no restart, continuous
    plan_typed(8'h00, 8'h00, 32'd0, KindNone, DelaySleep);
    plan_typed(8'hFF, 8'h00, 32'd0, KindNone, DelayFast);
    plan_typed(8'h00, 8'hFF, 32'd1000, KindNone, DelayFast);
    plan_typed(8'hFF, 8'hFF, 32'd5000, KindNone, DelayFast);
    plan_typed(8'h00, 8'hFF, 32'd3001, KindCont, DelaySlow);
    plan_eval(8'h00, 8'h0F, 32'd3001);
    plan_eval(8'h00, 8'h00, 32'd3002);
    // Hold time across the tick wrap, exactly at the long limit
    plan_eval(8'h01, 8'h00, 32'hFFFF_FF00);
    plan_eval(8'h00, 8'h00, 32'h0000_02E8);
    // Long release at the continuous boundary; highest button sets the delay
    plan_eval(8'h81, 8'h00, 32'd0);
    plan_eval(8'h00, 8'h80, 32'd3000);
    plan_eval(8'h01, 8'h81, 32'd4000);
    plan_eval(8'h00, 8'h00, 32'd4000);
    // Both limits at zero
    plan_limits(16'h0000, 16'h0000);
    plan_typed(8'hFF, 8'h00, 32'd100, KindNone, DelayFast);
    plan_typed(8'h00, 8'h00, 32'd100, KindShort, DelaySleep);
    plan_eval(8'hFF, 8'h00, 32'd7);
    plan_eval(8'h00, 8'h0F, 32'd8);
    // Both limits at maximum
    plan_limits(16'hFFFF, 16'hFFFF);
    plan_typed(8'hFF, 8'h00, 32'd0, KindNone, DelayFast);
    plan_typed(8'h00, 8'h00, 32'd65535, KindShort, DelaySleep);
    plan_typed(8'hFF, 8'h00, 32'd1, KindNone, DelayFast);
    plan_typed(8'h00, 8'hFF, 32'd65537, KindCont, DelaySlow);
    plan_typed(8'h00, 8'h00, 32'd65537, KindRelCont, DelaySleep);
    // Long limit above continuous limit
    plan_limits(16'd5000, 16'd2000);
    plan_eval(8'h01, 8'h00, 32'd0);
    plan_eval(8'h80, 8'h01, 32'd3000);
    plan_eval(8'h00, 8'h00, 32'd4000);
    plan_eval(8'h02, 8'h00, 32'd0);
    plan_eval(8'h00, 8'h00, 32'd6000);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) write_limits(plan_q[i].long_lim, plan_q[i].cont_lim);
      else send_eval(plan_q[i].clicked, plan_q[i].level, plan_q[i].tick, plan_q[i].typed,
                     plan_q[i].kind, plan_q[i].delay);
    end

    // Random phases: mostly realistic press and release sequences, some noise
    phys = '0;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin lng = 16'h0000; cnt = 16'h0000; end
        1: begin lng = 16'hFFFF; cnt = 16'hFFFF; end
        2: begin lng = 16'd5000; cnt = 16'd2000; end
        3: begin lng = LongLimitReset; cnt = ContLimitReset; end
        default: begin
          lng = $urandom_range(0, 800);
          cnt = $urandom_range(0, 2000);
        end
      endcase
      write_limits(lng, cnt);
      span = ((lng > cnt) ? lng : cnt) / 3 + 40;
      tick = (ph == 1) ? (32'hFFFF_0000 | $urandom_range(0, 65535)) : $urandom;
      send_calm = (ph == 4);
      repeat (36) begin
        pick = $urandom_range(0, 9);
        tick = (pick == 1) ? $urandom : tick + $urandom_range(0, span);
        if (pick == 0) begin
          c = $urandom;
          l = $urandom;
        end else begin
          flips = $urandom & $urandom;
          l = phys ^ flips;
          c = l & ~phys;
          phys = l;
          // short bounce: pressed and let go between two evaluations
          if (pick == 2) c = c | ($urandom & $urandom & ~l);
        end
        send_eval(c, l, tick, 1'b0, KindNone, DelaySleep);
      end
    end

    push <= 1'b0;
    while (exp_res_q.size() != 0) @(posedge clk_i);
    repeat (NumButtons + 4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: pop with random stalls, compare each transaction with the oldest expectation
  initial begin : result_sink
    res_t want;
    int   left;
    bit   calm;
    left = 0;
    calm = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (pop && !empty) begin
          if (exp_res_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual button %0d kind %0d",
                     $time, button_index_o, event_kind_o);
            mismatch_cnt++;
          end else begin
            want = exp_res_q.pop_front();
            check_field("button_index", want.index, button_index_o);
            check_field("event_kind", want.kind, event_kind_o);
            check_field("next_check_ms", want.next_check, next_check_ms_o);
            check_field("last_result", want.last, last_result_o);
          end
          if ($urandom_range(0, 49) == 0) calm = !calm;
          left = draw_wait(calm);
          if (left > 0) pop <= 1'b0;
        end else if (!pop) begin
          if (left > 0) left--;
          if (left == 0) pop <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
